// ===== sv/lfps_pkg.sv =====
// Shared constants, types and tables for the line follower PID steering block.
// Depends on nothing; every other file of the block but lfps_fifo imports it.
package lfps_pkg;

  localparam int SENSOR_COUNT = 7;
  localparam int SENS_W = 10;
  localparam int ERR_W = 7;
  localparam int GAIN_W = 32;
  localparam int SPEED_CFG_W = 12;
  localparam int SPEED_W = 13;
  localparam int FRAC_W = 16;
  localparam int IP_CAP_LOG2 = 50;
  localparam int INTEGRAL_WIDTH_DEFAULT = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [SPEED_W-1:0] SPEED_CREEP = 13'sd26;
  localparam logic signed [SPEED_W-1:0] SPEED_TURN = 13'sd1562;

  localparam logic signed [ERR_W-1:0] WEIGHT_TAB [SENSOR_COUNT] =
    '{-7'sd20, -7'sd10, -7'sd5, 7'sd0, 7'sd5, 7'sd10, 7'sd20};

  typedef enum logic [1:0] {
    CMD_PID  = 2'd0,
    CMD_VEER = 2'd1,
    CMD_TURN = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VEER_NONE,
    VEER_BASE_LEFT,
    VEER_BASE_RIGHT
  } veer_t;

  typedef enum logic [1:0] {
    MAIN_PID,
    MAIN_TURN_LEFT,
    MAIN_TURN_RIGHT
  } main_t;

  typedef enum logic [2:0] {
    REG_SENSE_THRESHOLD = 3'd0,
    REG_RED_LEVEL       = 3'd1,
    REG_BLACK_LEVEL     = 3'd2,
    REG_GAIN_P          = 3'd3,
    REG_GAIN_I          = 3'd4,
    REG_GAIN_D          = 3'd5,
    REG_BASE_SPEED      = 3'd6,
    REG_SPEED_CAP       = 3'd7
  } reg_idx_t;

  typedef logic [SENSOR_COUNT-1:0][SENS_W-1:0] sample_t;

  typedef struct packed {
    logic [SENS_W-1:0]      sense_threshold;
    logic [SENS_W-1:0]      red_level;
    logic [SENS_W-1:0]      black_level;
    logic [GAIN_W-1:0]      gain_p;
    logic [GAIN_W-1:0]      gain_i;
    logic [GAIN_W-1:0]      gain_d;
    logic [SPEED_CFG_W-1:0] base_speed;
    logic [SPEED_CFG_W-1:0] speed_cap;
  } cfg_t;

  typedef struct packed {
    veer_t                   veer;
    main_t                   main_op;
    logic signed [ERR_W-1:0] err;
    logic                    stop;
  } job_t;

  localparam cfg_t CFG_RESET = '{
    sense_threshold: 10'd300,
    red_level:       10'd300,
    black_level:     10'd500,
    gain_p:          32'd8388608,
    gain_i:          32'd17,
    gain_d:          32'd1678,
    base_speed:      12'd1608,
    speed_cap:       12'd3144
  };

endpackage

// ===== sv/lfps_front.sv =====
// Front end: accepts sensor samples and classifies each one into a job.
// Depends on lfps_pkg; pushes jobs into the queue that feeds the back end.
module lfps_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  lfps_pkg::sample_t sample,
  input  lfps_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output lfps_pkg::job_t  q_job
);
  import lfps_pkg::*;

  localparam logic [SENSOR_COUNT-1:0] PAT_OUTER_LEFT = SENSOR_COUNT'(3);
  localparam logic [SENSOR_COUNT-1:0] PAT_OUTER_RIGHT =
    SENSOR_COUNT'(3) << (SENSOR_COUNT - 2);

  logic [SENSOR_COUNT-1:0] line_bits;
  logic                    all_black;
  logic signed [ERR_W-1:0] err;
  logic [SENS_W-1:0]       first_s;
  logic [SENS_W-1:0]       last_s;
  logic                    marker;

  assign first_s = sample[0];
  assign last_s  = sample[SENSOR_COUNT-1];

  always_comb begin
    line_bits = '0;
    all_black = 1'b1;
    err = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      line_bits[i] = sample[i] > cfg.sense_threshold;
      if (sample[i] <= cfg.black_level) all_black = 1'b0;
      if (line_bits[i]) err = err + WEIGHT_TAB[i];
    end
  end

  assign marker =
    (first_s < cfg.red_level && last_s > cfg.red_level && last_s < cfg.black_level) ||
    (last_s < cfg.red_level && first_s > cfg.red_level && first_s < cfg.black_level);

  always_comb begin
    q_job.veer = VEER_NONE;
    if (marker) begin
      if (first_s > cfg.red_level && first_s < cfg.sense_threshold) begin
        q_job.veer = VEER_BASE_LEFT;
      end else if (last_s > cfg.red_level && last_s < cfg.sense_threshold) begin
        q_job.veer = VEER_BASE_RIGHT;
      end
    end
    if (line_bits == PAT_OUTER_LEFT) begin
      q_job.main_op = MAIN_TURN_LEFT;
    end else if (line_bits == PAT_OUTER_RIGHT) begin
      q_job.main_op = MAIN_TURN_RIGHT;
    end else begin
      q_job.main_op = MAIN_PID;
    end
    q_job.err  = err;
    q_job.stop = all_black;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== sv/lfps_fifo.sv =====
// Short job queue between the front end and the back end.
// Depends on nothing; width and depth come from the instantiating level.
module lfps_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && !full;
  assign pop      = rd_ready && rd_valid;
  assign rd_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/lfps_pid.sv =====
// Back end: seven-stage PID pipeline that holds the error state and computes
// the drive speeds. Depends on lfps_pkg; every job passes through in order.
module lfps_pid #(
  parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lfps_pkg::cfg_t                         cfg,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  lfps_pkg::job_t                         up_job,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output lfps_pkg::job_t                         dn_job,
  output logic signed [lfps_pkg::SPEED_W-1:0]    dn_left,
  output logic signed [lfps_pkg::SPEED_W-1:0]    dn_right
);
  import lfps_pkg::*;

  localparam int IW = INTEGRAL_WIDTH;
  localparam int STAGES = 7;
  localparam int D_W = ERR_W + 1;
  localparam int PE_W = ERR_W + GAIN_W + 1;
  localparam int PD_W = D_W + GAIN_W + 1;
  localparam int PED_W = PD_W + 1;
  localparam int H = (IW + 1) / 2;
  localparam int HI = IW - H;
  localparam int LO_W = H + GAIN_W;
  localparam int HI_W = HI + GAIN_W;
  localparam int IP_W = IP_CAP_LOG2 + 1;
  localparam int SUM_W = (IW + GAIN_W > IP_W) ? IW + GAIN_W : IP_W;
  localparam int T_W = ((PED_W > IP_W) ? PED_W : IP_W) + 2;
  localparam int V_W = T_W + 1;
  localparam int RND_W = SPEED_CFG_W + FRAC_W + 1;
  localparam logic [SUM_W-1:0] IP_CAP = SUM_W'(1) << IP_CAP_LOG2;

  function automatic logic signed [SPEED_W-1:0] motor_cmd(
    input logic [V_W-1:0]         v,
    input logic [SPEED_CFG_W-1:0] vmax
  );
    logic [V_W-1:0]          top;
    logic [RND_W-1:0]        rnd;
    logic signed [SPEED_W-1:0] res;
    top = {{(V_W - SPEED_CFG_W - FRAC_W){1'b0}}, vmax, {FRAC_W{1'b0}}};
    rnd = {1'b0, v[SPEED_CFG_W+FRAC_W-1:0]} + RND_W'(1 << (FRAC_W - 1));
    if (v[V_W-1]) begin
      res = SPEED_CREEP;
    end else if (v > top) begin
      res = -$signed({1'b0, vmax});
    end else begin
      res = -$signed({1'b0, rnd[SPEED_CFG_W+FRAC_W-1:FRAC_W]});
    end
    return res;
  endfunction

  logic                    vld_r [STAGES];
  job_t                    job_r [STAGES];
  logic                    adv;
  logic                    take;

  logic signed [IW-1:0]    err_sum_r;
  logic signed [ERR_W-1:0] prev_err_r;
  logic [IW:0]             sum_ext;
  logic [IW-1:0]           sum_nxt;
  logic [D_W-1:0]          d_nxt;

  logic signed [D_W-1:0]   d1_r;
  logic signed [IW-1:0]    es1_r;
  logic signed [GAIN_W:0]  gp_s;
  logic signed [GAIN_W:0]  gd_s;
  logic signed [PE_W-1:0]  pe_nxt;
  logic signed [PD_W-1:0]  pd_nxt;
  logic [IW-1:0]           mag_nxt;
  logic signed [PE_W-1:0]  pe2_r;
  logic signed [PD_W-1:0]  pd2_r;
  logic [IW-1:0]           mag2_r;
  logic                    neg2_r;
  logic [LO_W-1:0]         ilo3_r;
  logic [HI_W-1:0]         ihi3_r;
  logic [PED_W-1:0]        ped3_r;
  logic                    neg3_r;
  logic [SUM_W-1:0]        ip_full;
  logic [IP_W-1:0]         ip4_r;
  logic [PED_W-1:0]        ped4_r;
  logic                    neg4_r;
  logic [T_W-1:0]          ped_ext;
  logic [T_W-1:0]          ip_ext;
  logic [T_W-1:0]          t5_r;
  logic [V_W-1:0]          base_ext;
  logic [V_W-1:0]          t_ext;
  logic [V_W-1:0]          vl6_r;
  logic [V_W-1:0]          vr6_r;
  logic signed [SPEED_W-1:0] left7_r;
  logic signed [SPEED_W-1:0] right7_r;

  assign adv      = !vld_r[STAGES-1] || dn_ready;
  assign up_ready = adv;
  assign take     = up_valid && adv;

  assign sum_ext = {err_sum_r[IW-1], err_sum_r} +
                   {{(IW + 1 - ERR_W){up_job.err[ERR_W-1]}}, up_job.err};
  assign sum_nxt = (sum_ext[IW] != sum_ext[IW-1]) ?
                   (sum_ext[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}}) :
                   sum_ext[IW-1:0];
  assign d_nxt   = {up_job.err[ERR_W-1], up_job.err} - {prev_err_r[ERR_W-1], prev_err_r};

  assign gp_s    = $signed({1'b0, cfg.gain_p});
  assign gd_s    = $signed({1'b0, cfg.gain_d});
  assign pe_nxt  = job_r[0].err * gp_s;
  assign pd_nxt  = d1_r * gd_s;
  assign mag_nxt = es1_r[IW-1] ? (~es1_r + 1'b1) : es1_r;

  assign ip_full = (SUM_W'(ihi3_r) << H) + SUM_W'(ilo3_r);

  assign ped_ext = {{(T_W - PED_W){ped4_r[PED_W-1]}}, ped4_r};
  assign ip_ext  = {{(T_W - IP_W){1'b0}}, ip4_r};

  assign base_ext = {{(V_W - SPEED_CFG_W - FRAC_W){1'b0}}, cfg.base_speed, {FRAC_W{1'b0}}};
  assign t_ext    = {t5_r[T_W-1], t5_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
      err_sum_r  <= '0;
      prev_err_r <= '0;
    end else begin
      if (adv) begin
        vld_r[0] <= up_valid;
        for (int k = 1; k < STAGES; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (take && up_job.main_op == MAIN_PID) begin
        err_sum_r  <= sum_nxt;
        prev_err_r <= up_job.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r[0] <= up_job;
      for (int k = 1; k < STAGES; k++) begin
        job_r[k] <= job_r[k-1];
      end
      d1_r     <= d_nxt;
      es1_r    <= sum_nxt;
      pe2_r    <= pe_nxt;
      pd2_r    <= pd_nxt;
      mag2_r   <= mag_nxt;
      neg2_r   <= es1_r[IW-1];
      ilo3_r   <= mag2_r[H-1:0] * cfg.gain_i;
      ihi3_r   <= mag2_r[IW-1:H] * cfg.gain_i;
      ped3_r   <= {{(PED_W - PE_W){pe2_r[PE_W-1]}}, pe2_r} +
                  {{(PED_W - PD_W){pd2_r[PD_W-1]}}, pd2_r};
      neg3_r   <= neg2_r;
      ip4_r    <= (ip_full > IP_CAP) ? IP_CAP[IP_W-1:0] : ip_full[IP_W-1:0];
      ped4_r   <= ped3_r;
      neg4_r   <= neg3_r;
      t5_r     <= neg4_r ? (ped_ext - ip_ext) : (ped_ext + ip_ext);
      vl6_r    <= base_ext - t_ext;
      vr6_r    <= base_ext + t_ext;
      left7_r  <= motor_cmd(vl6_r, cfg.speed_cap);
      right7_r <= motor_cmd(vr6_r, cfg.speed_cap);
    end
  end

  assign dn_valid = vld_r[STAGES-1];
  assign dn_job   = job_r[STAGES-1];
  assign dn_left  = left7_r;
  assign dn_right = right7_r;

endmodule

// ===== sv/lfps_emit.sv =====
// Result sequencer: expands one finished job into its one to three result
// requests and drives the output register. Depends on lfps_pkg.
module lfps_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfps_pkg::cfg_t                      cfg,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  lfps_pkg::job_t                      up_job,
  input  logic signed [lfps_pkg::SPEED_W-1:0] up_left,
  input  logic signed [lfps_pkg::SPEED_W-1:0] up_right,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lfps_pkg::cmd_t                      out_command,
  output logic signed [lfps_pkg::SPEED_W-1:0] out_left_speed,
  output logic signed [lfps_pkg::SPEED_W-1:0] out_right_speed,
  output logic                                out_last
);
  import lfps_pkg::*;

  localparam int SLOT_VEER = 0;
  localparam int SLOT_MAIN = 1;
  localparam int SLOT_STOP = 2;

  logic [2:0]                pend_r;
  logic [2:0]                pend_nxt;
  job_t                      job_r;
  logic signed [SPEED_W-1:0] pl_r;
  logic signed [SPEED_W-1:0] pr_r;
  logic                      out_valid_r;
  cmd_t                      cmd_r;
  logic signed [SPEED_W-1:0] left_r;
  logic signed [SPEED_W-1:0] right_r;
  logic                      last_r;

  logic [2:0]                pick;
  logic [2:0]                rest;
  logic                      out_free;
  logic                      fire;
  logic                      take;
  logic signed [SPEED_W-1:0] base_s;
  cmd_t                      cmd_nxt;
  logic signed [SPEED_W-1:0] left_nxt;
  logic signed [SPEED_W-1:0] right_nxt;

  assign pick     = pend_r & (~pend_r + 3'd1);
  assign rest     = pend_r & ~pick;
  assign out_free = !out_valid_r || out_ready;
  assign fire     = out_free && (pend_r != '0);
  assign up_ready = (pend_r == '0) || (fire && rest == '0);
  assign take     = up_valid && up_ready;
  assign base_s   = $signed({1'b0, cfg.base_speed});

  always_comb begin
    if (take) begin
      pend_nxt = {up_job.stop, 1'b1, up_job.veer != VEER_NONE};
    end else if (fire) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_comb begin
    cmd_nxt   = CMD_STOP;
    left_nxt  = '0;
    right_nxt = '0;
    if (pick[SLOT_VEER]) begin
      cmd_nxt = CMD_VEER;
      if (job_r.veer == VEER_BASE_LEFT) begin
        left_nxt  = base_s;
        right_nxt = SPEED_CREEP;
      end else begin
        left_nxt  = SPEED_CREEP;
        right_nxt = base_s;
      end
    end else if (pick[SLOT_MAIN]) begin
      case (job_r.main_op)
        MAIN_TURN_LEFT: begin
          cmd_nxt   = CMD_TURN;
          left_nxt  = SPEED_CREEP;
          right_nxt = SPEED_TURN;
        end
        MAIN_TURN_RIGHT: begin
          cmd_nxt   = CMD_TURN;
          left_nxt  = SPEED_TURN;
          right_nxt = SPEED_CREEP;
        end
        default: begin
          cmd_nxt   = CMD_PID;
          left_nxt  = pl_r;
          right_nxt = pr_r;
        end
      endcase
    end else if (pick[SLOT_STOP]) begin
      cmd_nxt = CMD_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= up_job;
      pl_r  <= up_left;
      pr_r  <= up_right;
    end
    if (fire) begin
      cmd_r   <= cmd_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      last_r  <= rest == '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = cmd_r;
  assign out_left_speed  = left_r;
  assign out_right_speed = right_r;
  assign out_last        = last_r;

endmodule

// ===== sv/line_follower_pid_steer.sv =====
// Top level of the line follower PID steering block: configuration registers,
// front end, job queue, PID back end and result sequencer. Depends on lfps_pkg.
// Each request on the input channel is one sample of seven line sensors; it
// answers with one to three result requests (optional marker veer, then a PID
// drive or sharp turn, then an optional stop), the final one flagged by
// out_last. A sample is taken in every cycle while the four-entry job queue
// has room, and results leave at one per cycle through the output register
// while out_ready allows, so that single result port sets the sustained
// sample rate. A sample's first result passes through the queue, the
// seven-stage PID pipeline, the sequencer and the output register. The error
// state is updated as each PID job enters the pipeline, so consecutive
// samples need no gap. Configuration writes are taken in every cycle and must
// only be made while no sample is in flight.
module line_follower_pid_steer #(
  parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_1,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_2,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_3,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_4,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_5,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_6,
  input  logic [lfps_pkg::SENS_W-1:0]          in_sensor_7,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_command,
  output logic signed [lfps_pkg::SPEED_W-1:0]  out_left_speed,
  output logic signed [lfps_pkg::SPEED_W-1:0]  out_right_speed,
  output logic                                 out_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [lfps_pkg::GAIN_W-1:0]          cfg_data
);
  import lfps_pkg::*;

  cfg_t                      cfg_r;
  sample_t                   sample;
  logic                      q_full;
  logic                      q_push;
  job_t                      q_wr_job;
  logic                      q_vld;
  logic                      q_pop;
  job_t                      q_rd_job;
  logic                      p_vld;
  logic                      p_rdy;
  job_t                      p_job;
  logic signed [SPEED_W-1:0] p_left;
  logic signed [SPEED_W-1:0] p_right;
  cmd_t                      e_cmd;

  assign sample[0] = in_sensor_1;
  assign sample[1] = in_sensor_2;
  assign sample[2] = in_sensor_3;
  assign sample[3] = in_sensor_4;
  assign sample[4] = in_sensor_5;
  assign sample[5] = in_sensor_6;
  assign sample[6] = in_sensor_7;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SENSE_THRESHOLD: cfg_r.sense_threshold <= cfg_data[SENS_W-1:0];
        REG_RED_LEVEL:       cfg_r.red_level       <= cfg_data[SENS_W-1:0];
        REG_BLACK_LEVEL:     cfg_r.black_level     <= cfg_data[SENS_W-1:0];
        REG_GAIN_P:          cfg_r.gain_p          <= cfg_data;
        REG_GAIN_I:          cfg_r.gain_i          <= cfg_data;
        REG_GAIN_D:          cfg_r.gain_d          <= cfg_data;
        REG_BASE_SPEED:      cfg_r.base_speed      <= cfg_data[SPEED_CFG_W-1:0];
        REG_SPEED_CAP:       cfg_r.speed_cap       <= cfg_data[SPEED_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  lfps_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_wr_job)
  );

  lfps_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_push),
    .wr_data  (q_wr_job),
    .full     (q_full),
    .rd_valid (q_vld),
    .rd_ready (q_pop),
    .rd_data  (q_rd_job)
  );

  lfps_pid #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_pid (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (q_vld),
    .up_ready (q_pop),
    .up_job   (q_rd_job),
    .dn_valid (p_vld),
    .dn_ready (p_rdy),
    .dn_job   (p_job),
    .dn_left  (p_left),
    .dn_right (p_right)
  );

  lfps_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .up_valid        (p_vld),
    .up_ready        (p_rdy),
    .up_job          (p_job),
    .up_left         (p_left),
    .up_right        (p_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_command     (e_cmd),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_last        (out_last)
  );

  assign out_command = e_cmd;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_stop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_STOP |-> out_last)
    else $error("Stop result not flagged as final.");

  a_veer_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_VEER |-> !out_last)
    else $error("Veer result flagged as final.");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld && !p_rdy |=> p_vld && $stable(p_job) && $stable(p_left) && $stable(p_right))
    else $error("PID pipeline output changed while stalled.");

endmodule
